FILE: sv/dtfp_pkg.sv
// Shared constants, types and the fraction scale table for the decimal text parser.
// Used by dtfp_scan, dtfp_scale, dtfp_emit and the top level.
package dtfp_pkg;

    localparam int INT_DIGITS  = 6;
    localparam int FRAC_DIGITS = 6;

    localparam int CHAR_W     = 8;
    localparam int VAL_W      = 41;
    localparam int MAX_DIGITS = (INT_DIGITS > FRAC_DIGITS) ? INT_DIGITS : FRAC_DIGITS;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int INT_W      = $clog2(10 ** INT_DIGITS);
    localparam int FRAC_W     = $clog2(10 ** FRAC_DIGITS);
    localparam int POW_W      = $clog2(10 ** FRAC_DIGITS + 1);

    localparam int INT_PROD_W  = INT_W + POW_W;
    localparam int FRAC_PROD_W = FRAC_W + POW_W;
    localparam int PROD_MAX_W  = (INT_PROD_W > FRAC_PROD_W) ? INT_PROD_W : FRAC_PROD_W;
    localparam int WIDE_W      = (PROD_MAX_W > VAL_W) ? PROD_MAX_W : VAL_W;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Entry n <= FRAC_DIGITS holds 10^(FRAC_DIGITS-n): pads n digits to full scale.
    typedef logic [POW_W-1:0] scale_tbl_t [2**CNT_W];

    function automatic scale_tbl_t build_scale();
        scale_tbl_t tbl;
        longint     p;
        for (int i = 0; i < 2**CNT_W; i++)
        begin
            tbl[i] = '0;
        end
        for (int i = 0; i <= FRAC_DIGITS; i++)
        begin
            p = 1;
            for (int k = 0; k < FRAC_DIGITS - i; k++)
            begin
                p = p * 10;
            end
            tbl[i] = POW_W'(p);
        end
        return tbl;
    endfunction

    localparam scale_tbl_t        FRAC_SCALE = build_scale();
    localparam logic [POW_W-1:0]  INT_SCALE  = POW_W'(10 ** FRAC_DIGITS);

    // Parser state captured at the terminator
    typedef struct packed {
        logic              err;
        logic              neg;
        logic [INT_W-1:0]  int_acc;
        logic [FRAC_W-1:0] frac_acc;
        logic [CNT_W-1:0]  frac_cnt;
    } snap_t;

    // Scaled integer and fraction parts
    typedef struct packed {
        logic                   err;
        logic                   neg;
        logic [INT_PROD_W-1:0]  int_prod;
        logic [FRAC_PROD_W-1:0] frac_prod;
    } prod_t;

endpackage

FILE: sv/decimal_text_to_fixed_parser_unit.sv
// Top level of the decimal text to fixed-point parser.
// Instantiates dtfp_scan, dtfp_scale and dtfp_emit; depends on dtfp_pkg.
//
// Input channel (in_valid / in_stall / text_char): one character code per
// transfer. Code 0 ends the text and produces exactly one result; all other
// codes produce none.
// Output channel (out_valid / out_stall / value_millionths / parse_error):
// the parsed value times 10^6 in two's complement, or 0 with parse_error set
// when the text broke the number grammar.
// Throughput: one character per cycle, sustained, including back-to-back texts, while in_stall is low.
// A terminator passes through the input register, parser update (snapshot register),
// multiply stage and sum/sign stage to the result register.
// Each stage holds its own valid bit, so the input keeps taking characters
// while a result waits on out_stall; only when all three stages behind the
// parser are full does a terminator hold in_stall high.
// Reset (rst_n low, asynchronous) empties every stage and returns the parser
// to the leading-whitespace state with cleared accumulators.
module decimal_text_to_fixed_parser_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [dtfp_pkg::CHAR_W-1:0]        text_char,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [dtfp_pkg::VAL_W-1:0]  value_millionths,
    output logic                               parse_error
);
    import dtfp_pkg::*;

    snap_t snap;
    logic  snap_valid, snap_stall;
    prod_t prod;
    logic  prod_valid, prod_stall;

    dtfp_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_char  (text_char),
        .snap_valid (snap_valid),
        .snap_stall (snap_stall),
        .snap       (snap)
    );

    dtfp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_stall (snap_stall),
        .snap       (snap),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod)
    );

    dtfp_emit u_emit (
        .clk              (clk),
        .rst_n            (rst_n),
        .prod_valid       (prod_valid),
        .prod_stall       (prod_stall),
        .prod             (prod),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .value_millionths (value_millionths),
        .parse_error      (parse_error)
    );

endmodule

FILE: sv/dtfp_scan.sv
// Input register and character-level parser state machine.
// Emits a snapshot of the accumulators on the terminator. Depends on dtfp_pkg.
module dtfp_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dtfp_pkg::CHAR_W-1:0]   text_char,
    output logic                          snap_valid,
    input  logic                          snap_stall,
    output dtfp_pkg::snap_t               snap
);
    import dtfp_pkg::*;

    typedef enum logic [4:0] {
        PH_SPACE = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_INT   = 5'b00100,
        PH_DOT   = 5'b01000,
        PH_FRAC  = 5'b10000
    } phase_t;

    logic [CHAR_W-1:0] char_reg;
    logic              char_vld_reg;
    logic              char_vld_next;

    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              err_reg, err_next;

    snap_t             snap_reg;
    logic              snap_vld_reg, snap_vld_next;

    logic              is_term, is_space, is_sign, is_digit, is_dot;
    logic [3:0]        digit_val;
    logic              snap_free, take, in_xfer;

    assign is_term   = (char_reg == CHAR_NUL);
    assign is_space  = (char_reg inside {[CHAR_TAB:CHAR_CR]}) || (char_reg == CHAR_SPACE);
    assign is_sign   = (char_reg == CHAR_PLUS) || (char_reg == CHAR_MINUS);
    assign is_digit  = char_reg inside {[CHAR_ZERO:CHAR_NINE]};
    assign is_dot    = (char_reg == CHAR_DOT);
    assign digit_val = char_reg[3:0];

    // Non-terminators always drain; the terminator needs room in the snapshot slot.
    assign snap_free = !snap_vld_reg || !snap_stall;
    assign take      = char_vld_reg && (!is_term || snap_free);
    assign in_stall  = char_vld_reg && !take;
    assign in_xfer   = in_valid && !in_stall;

    assign char_vld_next = in_xfer ? 1'b1 : (take ? 1'b0 : char_vld_reg);
    assign snap_vld_next = (take && is_term) ? 1'b1 : (snap_stall ? snap_vld_reg : 1'b0);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        err_next   = err_reg;
        if (take)
        begin
            if (is_term)
            begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                cnt_next   = '0;
                int_next   = '0;
                frac_next  = '0;
                err_next   = 1'b0;
            end
            else if (!err_reg)
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space)
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (char_reg == CHAR_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            int_next   = INT_W'(digit_val);
                            cnt_next   = CNT_W'(1);
                            phase_next = PH_INT;
                        end
                        else if (is_dot)
                        begin
                            phase_next = PH_DOT;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            int_next   = INT_W'(digit_val);
                            cnt_next   = CNT_W'(1);
                            phase_next = PH_INT;
                        end
                        else if (is_dot)
                        begin
                            phase_next = PH_DOT;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_INT:
                    begin
                        if (is_digit && (cnt_reg < CNT_W'(INT_DIGITS)))
                        begin
                            int_next = int_reg * INT_W'(10) + INT_W'(digit_val);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        else if (is_dot)
                        begin
                            cnt_next   = '0;
                            phase_next = PH_DOT;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_DOT:
                    begin
                        if (is_digit)
                        begin
                            frac_next  = FRAC_W'(digit_val);
                            cnt_next   = CNT_W'(1);
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_digit && (cnt_reg < CNT_W'(FRAC_DIGITS)))
                        begin
                            frac_next = frac_reg * FRAC_W'(10) + FRAC_W'(digit_val);
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_vld_reg <= 1'b0;
            snap_vld_reg <= 1'b0;
            phase_reg    <= PH_SPACE;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
            int_reg      <= '0;
            frac_reg     <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            char_vld_reg <= char_vld_next;
            snap_vld_reg <= snap_vld_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            cnt_reg      <= cnt_next;
            int_reg      <= int_next;
            frac_reg     <= frac_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            char_reg <= text_char;
        end
        if (take && is_term)
        begin
            // a text that does not end in a digit is an error
            snap_reg.err      <= err_reg || !((phase_reg == PH_INT) || (phase_reg == PH_FRAC));
            snap_reg.neg      <= neg_reg;
            snap_reg.int_acc  <= int_reg;
            snap_reg.frac_acc <= frac_reg;
            snap_reg.frac_cnt <= cnt_reg;
        end
    end

    assign snap_valid = snap_vld_reg;
    assign snap       = snap_reg;

endmodule

FILE: sv/dtfp_scale.sv
// Multiply stage: scales the integer part by 10^FRAC_DIGITS and pads the fraction.
// Depends on dtfp_pkg.
module dtfp_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snap_valid,
    output logic              snap_stall,
    input  dtfp_pkg::snap_t   snap,
    output logic              prod_valid,
    input  logic              prod_stall,
    output dtfp_pkg::prod_t   prod
);
    import dtfp_pkg::*;

    prod_t prod_reg;
    logic  prod_vld_reg, prod_vld_next;
    logic  load;

    assign snap_stall    = prod_vld_reg && prod_stall;
    assign load          = snap_valid && !snap_stall;
    assign prod_vld_next = load ? 1'b1 : (prod_stall ? prod_vld_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next;
        end
    end

    // Fraction accumulator is zero unless a fraction was read, so no phase check here.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg.err       <= snap.err;
            prod_reg.neg       <= snap.neg;
            prod_reg.int_prod  <= INT_PROD_W'(snap.int_acc) * INT_PROD_W'(INT_SCALE);
            prod_reg.frac_prod <= FRAC_PROD_W'(snap.frac_acc)
                                  * FRAC_PROD_W'(FRAC_SCALE[snap.frac_cnt]);
        end
    end

    assign prod_valid = prod_vld_reg;
    assign prod       = prod_reg;

endmodule

FILE: sv/dtfp_emit.sv
// Final stage: sums the scaled parts, applies the sign (or gives 0 on a parse error) and holds the result register.
// Depends on dtfp_pkg.
module dtfp_emit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               prod_valid,
    output logic                               prod_stall,
    input  dtfp_pkg::prod_t                    prod,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [dtfp_pkg::VAL_W-1:0]  value_millionths,
    output logic                               parse_error
);
    import dtfp_pkg::*;

    logic [VAL_W-1:0]  val_reg;
    logic              err_reg;
    logic              out_vld_reg, out_vld_next;
    logic              load;
    logic [WIDE_W-1:0] int_wide, frac_wide;
    logic [VAL_W-1:0]  a_term, b_term, carry_in, sum;

    assign prod_stall   = out_vld_reg && out_stall;
    assign load         = prod_valid && !prod_stall;
    assign out_vld_next = load ? 1'b1 : (out_stall ? out_vld_reg : 1'b0);

    // -(a+b) = ~a + ~b + 2, so the sign folds into one three-input add
    always_comb
    begin
        int_wide  = WIDE_W'(prod.int_prod);
        frac_wide = WIDE_W'(prod.frac_prod);
        a_term    = prod.neg ? ~int_wide[VAL_W-1:0]  : int_wide[VAL_W-1:0];
        b_term    = prod.neg ? ~frac_wide[VAL_W-1:0] : frac_wide[VAL_W-1:0];
        carry_in  = prod.neg ? VAL_W'(2) : '0;
        sum       = a_term + b_term + carry_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= prod.err ? '0 : sum;
            err_reg <= prod.err;
        end
    end

    assign out_valid        = out_vld_reg;
    assign value_millionths = val_reg;
    assign parse_error      = err_reg;

endmodule

FILE: dv/tb.sv
// Testbench for decimal_text_to_fixed_parser_unit: streams directed and random texts,
// predicts each terminator's fixed-point result and checks it in order.
// Depends on dtfp_pkg and the RTL of the parser unit.
module tb;
    import dtfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int RANDOM_CHARS   = 450;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [2:0]
    {
        PH_LEAD,
        PH_SIGNED,
        PH_INTEGER,
        PH_POINT,
        PH_FRACTION
    } parse_phase_e;

    typedef struct
    {
        logic signed [VAL_W-1:0] value;
        logic                    err;
    } fixed_result_t;

    class fixed_scoreboard;
        parse_phase_e    phase;
        logic            neg;
        int unsigned     digits;
        longint unsigned int_acc;
        longint unsigned frac_acc;
        logic            bad;
        fixed_result_t   pending_q[$];
        int              fails;

        function new();
            fails = 0;
            clear();
        endfunction

        function void clear();
            phase    = PH_LEAD;
            neg      = 1'b0;
            digits   = 0;
            int_acc  = 0;
            frac_acc = 0;
            bad      = 1'b0;
        endfunction

        function longint unsigned pow10(int n);
            longint unsigned p;
            p = 1;
            for (int i = 0; i < n; i++)
            begin
                p = p * 10;
            end
            return p;
        endfunction

        // Called for every accepted character transfer
        function void note_char(logic [CHAR_W-1:0] c);
            logic            is_sign;
            logic            is_digit;
            logic            is_blank;
            longint unsigned d;
            longint unsigned mag;
            fixed_result_t   r;
            is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            is_blank = ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
            d        = is_digit ? longint'(c - CHAR_ZERO) : 0;
            if (c == CHAR_NUL)
            begin
                r.err = bad || (phase == PH_LEAD) || (phase == PH_SIGNED) ||
                        (phase == PH_POINT);
                mag = 0;
                if (!r.err)
                begin
                    mag = int_acc * pow10(FRAC_DIGITS);
                    if (phase == PH_FRACTION && digits <= FRAC_DIGITS)
                    begin
                        mag = mag + frac_acc * pow10(FRAC_DIGITS - digits);
                    end
                    if (neg)
                    begin
                        mag = -mag;
                    end
                end
                r.value = mag[VAL_W-1:0];
                pending_q.push_back(r);
                clear();
                return;
            end
            if (bad)
            begin
                return;
            end
            case (phase)
                PH_LEAD:
                begin
                    if (is_blank)
                    begin
                    end
                    else if (is_sign)
                    begin
                        neg   = (c == CHAR_MINUS);
                        phase = PH_SIGNED;
                    end
                    else if (is_digit)
                    begin
                        int_acc = d;
                        digits  = 1;
                        phase   = PH_INTEGER;
                    end
                    else if (c == CHAR_DOT)
                    begin
                        phase = PH_POINT;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    if (is_digit)
                    begin
                        int_acc = d;
                        digits  = 1;
                        phase   = PH_INTEGER;
                    end
                    else if (c == CHAR_DOT)
                    begin
                        phase = PH_POINT;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_INTEGER:
                begin
                    if (is_digit && digits < INT_DIGITS)
                    begin
                        int_acc = int_acc * 10 + d;
                        digits++;
                    end
                    else if (c == CHAR_DOT)
                    begin
                        digits = 0;
                        phase  = PH_POINT;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_POINT:
                begin
                    if (is_digit)
                    begin
                        frac_acc = d;
                        digits   = 1;
                        phase    = PH_FRACTION;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                default:
                begin
                    if (is_digit && digits < FRAC_DIGITS)
                    begin
                        frac_acc = frac_acc * 10 + d;
                        digits++;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
            endcase
        endfunction

        function void check_result(logic signed [VAL_W-1:0] v, logic e);
            fixed_result_t r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, value %0d error %0b", $time, v, e);
                fails++;
                return;
            end
            r = pending_q.pop_front();
            if (v !== r.value)
            begin
                $display("%0t: value_millionths expected %0d actual %0d", $time, r.value, v);
                fails++;
            end
            if (e !== r.err)
            begin
                $display("%0t: parse_error expected %0b actual %0b", $time, r.err, e);
                fails++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [CHAR_W-1:0]       text_char = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] value_millionths;
    logic                    parse_error;

    fixed_scoreboard   sb = new();
    logic [CHAR_W-1:0] text_q[$];
    logic              in_idle    = 1'b1;
    logic              out_idle   = 1'b1;
    int                char_count = 0;

    decimal_text_to_fixed_parser_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .text_char        (text_char),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .value_millionths (value_millionths),
        .parse_error      (parse_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Outputs are sampled right after the edge, so they still hold pre-edge values.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_char <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_char(c);
        char_count++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
        begin
            send_char(text_q[i]);
        end
        send_char(CHAR_NUL);
    endtask

    function automatic void load_str(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            text_q.push_back(s[i]);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit(logic nines);
        return nines ? CHAR_NINE : CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed numbers; the rest get a stray character or are pure noise.
    task automatic gen_text();
        int   kind;
        int   n_int;
        int   n_frac;
        int   sel;
        logic nines;
        logic [CHAR_W-1:0] ch;
        text_q.delete();
        kind  = $urandom_range(0, 9);
        nines = ($urandom_range(0, 7) == 0);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 8))
            begin
                text_q.push_back(CHAR_W'($urandom_range(1, 255)));
            end
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            sel = $urandom_range(0, 6);
            text_q.push_back((sel == 6) ? CHAR_SPACE : CHAR_TAB + CHAR_W'(sel));
        end
        case ($urandom_range(0, 2))
            1: text_q.push_back(CHAR_PLUS);
            2: text_q.push_back(CHAR_MINUS);
            default: ;
        endcase
        n_int  = $urandom_range(0, INT_DIGITS);
        n_frac = (n_int == 0 || $urandom_range(0, 1)) ? $urandom_range(1, FRAC_DIGITS) : 0;
        repeat (n_int)
        begin
            text_q.push_back(rand_digit(nines));
        end
        if (n_frac > 0)
        begin
            text_q.push_back(CHAR_DOT);
            repeat (n_frac)
            begin
                text_q.push_back(rand_digit(nines));
            end
        end
        if (kind >= 7)
        begin
            case ($urandom_range(0, 4))
                0: ch = CHAR_PLUS;
                1: ch = CHAR_MINUS;
                2: ch = CHAR_DOT;
                3: ch = rand_digit(1'b0);
                default: ch = CHAR_W'($urandom_range(1, 255));
            endcase
            text_q.insert($urandom_range(0, text_q.size()), ch);
        end
    endtask

    initial
    begin
        int texts;
        texts = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_str("0");             send_text();
        load_str("-0");            send_text();
        load_str("+999999.999999"); send_text();
        load_str("-.5");           send_text();
        load_str("");              send_text();
        load_str("+-1");           send_text();
        load_str("1234567");       send_text();
        load_str(".");             send_text();
        load_str("1.2345678");     send_text();
        load_str(" \t\r\n- 7");    send_text();
        load_str("1..2");          send_text();
        text_q = '{8'h0B, 8'h0C, 8'h35, 8'hFF, 8'h01};
        send_text();

        while (char_count < RANDOM_CHARS)
        begin
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            gen_text();
            send_text();
            texts++;
            if (texts == 20)
            begin
                // Hold off the sender until the pipeline has drained
                in_valid <= 1'b0;
                while (sb.pending_q.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random stall before each transfer
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            gap = out_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            sb.check_result(value_millionths, parse_error);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dtfp_pkg.sv
sv/dtfp_scan.sv
sv/dtfp_scale.sv
sv/dtfp_emit.sv
sv/decimal_text_to_fixed_parser_unit.sv
dv/tb.sv
